// ===== rtl/huffman_tree_walk_decoder_unit_defines.svh =====
// Assertion macros shared by the decoder modules.
`ifndef HUFFMAN_TREE_WALK_DECODER_UNIT_DEFINES_SVH
`define HUFFMAN_TREE_WALK_DECODER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define HTWD_ASSERT_IMPLIES(name, cond, expr) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("htwd assertion failed");

`define HTWD_ASSERT_NEXT(name, cond, expr) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("htwd assertion failed");

`else

`define HTWD_ASSERT_IMPLIES(name, cond, expr)

`define HTWD_ASSERT_NEXT(name, cond, expr)

`endif

`endif

// ===== rtl/htwd_pkg.sv =====
package htwd_pkg;

   localparam int MAX_SYMBOLS = 256;
   localparam int NODE_DEPTH  = 2 * MAX_SYMBOLS;
   localparam int NODE_W      = $clog2(NODE_DEPTH);
   localparam int SYM_ADDR_W  = $clog2(MAX_SYMBOLS);
   localparam int SYM_W       = 8;
   localparam int CODE_W      = 8;
   localparam int TOP_BIT     = 7;
   localparam int BYTE_BITS   = TOP_BIT + 1;
   localparam int COUNT_W     = 4;
   localparam int REM_W       = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_DECODE = 1'b1
   } op_type;

   typedef struct packed {
      op_type                operation;
      logic [NODE_W-1:0]     node_index;
      logic [NODE_W-1:0]     left_child;
      logic [NODE_W-1:0]     right_child;
      logic [SYM_W-1:0]      leaf_symbol;
      logic [CODE_W-1:0]     code_byte;
      logic [COUNT_W-1:0]    bit_count;
   } req_type;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             last;
      logic             error;
   } rsp_type;

   typedef struct packed {
      logic                  is_write;
      logic                  sym_en;
      logic [NODE_W-1:0]     node;
      logic [NODE_W-1:0]     left;
      logic [NODE_W-1:0]     right;
      logic [SYM_W-1:0]      leaf_symbol;
      logic [CODE_W-1:0]     code;
      logic [COUNT_W-1:0]    bits;
   } walk_task_type;

   typedef struct packed {
      logic          valid;
      walk_task_type item;
   } queue_out_type;

endpackage

// ===== rtl/htwd_front.sv =====
`include "huffman_tree_walk_decoder_unit_defines.svh"

module htwd_front
   import htwd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_payload,
   output queue_out_type q_out,
   input  logic          q_pop
);

   walk_task_type             queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]      count_ff, count_in;
   logic [COUNT_W-1:0]        bits_sat;
   logic                      keep;
   logic                      push;
   logic                      pop;
   walk_task_type             task_new;

   assign req_stall = (count_ff == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));

   always_comb begin
      bits_sat = (req_payload.bit_count > COUNT_W'(BYTE_BITS)) ?
                 COUNT_W'(BYTE_BITS) : req_payload.bit_count;
      keep = (req_payload.operation == OP_WRITE) || (bits_sat != '0);
      task_new.is_write    = (req_payload.operation == OP_WRITE);
      task_new.sym_en      = (req_payload.node_index != '0) &&
                             (req_payload.node_index <= NODE_W'(MAX_SYMBOLS));
      task_new.node        = req_payload.node_index;
      task_new.left        = req_payload.left_child;
      task_new.right       = req_payload.right_child;
      task_new.leaf_symbol = req_payload.leaf_symbol;
      task_new.code        = req_payload.code_byte;
      task_new.bits        = bits_sat;
   end

   assign push = req_valid && !req_stall && keep;
   assign pop  = q_pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= task_new;
      end
   end

   assign q_out.valid = (count_ff != '0);
   assign q_out.item  = queue_ff[rd_ptr_ff];

   `HTWD_ASSERT_IMPLIES(a_empty_ptrs, (count_ff == '0), (wr_ptr_ff == rd_ptr_ff))

endmodule

// ===== rtl/htwd_back.sv =====
`include "huffman_tree_walk_decoder_unit_defines.svh"

module htwd_back
   import htwd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  queue_out_type     q_in,
   output logic              q_pop,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [NODE_W-1:0] csr_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_payload
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_ROOT,
      S_WALK,
      S_FLUSH
   } state_type;

   logic [2*NODE_W-1:0]   node_mem [NODE_DEPTH];
   logic [SYM_W-1:0]      sym_mem  [MAX_SYMBOLS];

   state_type             state_ff, state_in;
   logic [NODE_W-1:0]     root_ff, root_in;
   logic [NODE_W-1:0]     root_left_ff, root_left_in;
   logic [NODE_W-1:0]     root_right_ff, root_right_in;
   logic [NODE_W-1:0]     cur_node_ff, cur_node_in;
   logic [NODE_W-1:0]     cur_left_ff, cur_left_in;
   logic [NODE_W-1:0]     cur_right_ff, cur_right_in;
   logic                  refetch_ff, refetch_in;
   logic [CODE_W-1:0]     shift_ff, shift_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [SYM_W-1:0]      pend_sym_ff, pend_sym_in;
   logic                  pend_err_ff, pend_err_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic [2*NODE_W-1:0]   node_rd_ff;
   logic [SYM_W-1:0]      sym_rd_ff;
   logic [NODE_W-1:0]     rd_node_ff;
   logic                  rd_symok_ff;

   walk_task_type         item;
   logic                  rd_en;
   logic [NODE_W-1:0]     rd_addr;
   logic [SYM_ADDR_W-1:0] sym_rd_addr;
   logic                  rd_symok;
   logic                  node_we;
   logic                  sym_we;
   logic [SYM_ADDR_W-1:0] sym_wr_addr;
   logic [NODE_W-1:0]     rd_left;
   logic [NODE_W-1:0]     rd_right;
   logic                  walk_err;
   logic                  walk_emit;
   logic [SYM_W-1:0]      res_symbol;
   logic                  out_free;
   logic [NODE_W-1:0]     nxt_node;
   logic [NODE_W-1:0]     nxt_left;
   logic [NODE_W-1:0]     nxt_right;
   logic [NODE_W-1:0]     n_sat;
   logic [NODE_W-1:0]     n_m1;
   logic [NODE_W-1:0]     new_root;

   assign item      = q_in.item;
   assign csr_ready = 1'b1;

   assign rd_left    = node_rd_ff[2*NODE_W-1:NODE_W];
   assign rd_right   = node_rd_ff[NODE_W-1:0];
   assign walk_err   = (rd_node_ff == '0);
   assign walk_emit  = walk_err || ((rd_left == '0) && (rd_right == '0));
   assign res_symbol = (!walk_err && rd_symok_ff) ? sym_rd_ff : '0;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign sym_rd_addr = SYM_ADDR_W'(rd_addr - 1'b1);
   assign rd_symok    = (rd_addr != '0) && (rd_addr <= NODE_W'(MAX_SYMBOLS));
   assign sym_wr_addr = SYM_ADDR_W'(item.node - 1'b1);

   always_comb begin
      if (csr_data < NODE_W'(2)) begin
         n_sat = NODE_W'(2);
      end else if (csr_data > NODE_W'(MAX_SYMBOLS)) begin
         n_sat = NODE_W'(MAX_SYMBOLS);
      end else begin
         n_sat = csr_data;
      end
      n_m1     = n_sat - 1'b1;
      new_root = {n_m1[NODE_W-2:0], 1'b1};
   end

   always_comb begin
      state_in      = state_ff;
      root_in       = root_ff;
      root_left_in  = root_left_ff;
      root_right_in = root_right_ff;
      cur_node_in   = cur_node_ff;
      cur_left_in   = cur_left_ff;
      cur_right_in  = cur_right_ff;
      refetch_in    = refetch_ff;
      shift_in      = shift_ff;
      rem_in        = rem_ff;
      pend_valid_in = pend_valid_ff;
      pend_sym_in   = pend_sym_ff;
      pend_err_in   = pend_err_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      q_pop         = 1'b0;
      node_we       = 1'b0;
      sym_we        = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = '0;
      nxt_node      = rd_node_ff;
      nxt_left      = rd_left;
      nxt_right     = rd_right;

      unique case (state_ff)
         S_IDLE: begin
            if (refetch_ff) begin
               rd_en      = 1'b1;
               rd_addr    = root_ff;
               refetch_in = 1'b0;
               state_in   = S_ROOT;
            end else if (q_in.valid) begin
               q_pop = 1'b1;
               if (item.is_write) begin
                  node_we = 1'b1;
                  sym_we  = item.sym_en;
                  if (item.node == cur_node_ff) begin
                     cur_left_in  = item.left;
                     cur_right_in = item.right;
                  end
                  if (item.node == root_ff) begin
                     root_left_in  = item.left;
                     root_right_in = item.right;
                  end
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = item.code[TOP_BIT] ? cur_right_ff : cur_left_ff;
                  shift_in = item.code << 1;
                  rem_in   = REM_W'(item.bits - 1'b1);
                  state_in = S_WALK;
               end
            end
         end
         S_ROOT: begin
            root_left_in  = rd_left;
            root_right_in = rd_right;
            cur_node_in   = root_ff;
            cur_left_in   = rd_left;
            cur_right_in  = rd_right;
            state_in      = S_IDLE;
         end
         S_WALK: begin
            if (!(walk_emit && pend_valid_ff && !out_free)) begin
               if (walk_emit) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{symbol: pend_sym_ff, last: 1'b0, error: pend_err_ff};
                  end
                  pend_valid_in = 1'b1;
                  pend_sym_in   = res_symbol;
                  pend_err_in   = walk_err;
                  nxt_node      = root_ff;
                  nxt_left      = root_left_ff;
                  nxt_right     = root_right_ff;
               end
               cur_node_in  = nxt_node;
               cur_left_in  = nxt_left;
               cur_right_in = nxt_right;
               if (rem_ff != '0) begin
                  rd_en    = 1'b1;
                  rd_addr  = shift_ff[TOP_BIT] ? nxt_right : nxt_left;
                  shift_in = shift_ff << 1;
                  rem_in   = rem_ff - 1'b1;
               end else begin
                  state_in = S_FLUSH;
               end
            end
         end
         S_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_in        = '{symbol: pend_sym_ff, last: 1'b1, error: pend_err_ff};
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_valid) begin
         root_in     = new_root;
         cur_node_in = new_root;
         refetch_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         root_ff       <= NODE_W'(3);
         root_left_ff  <= '0;
         root_right_ff <= '0;
         cur_node_ff   <= NODE_W'(3);
         cur_left_ff   <= '0;
         cur_right_ff  <= '0;
         refetch_ff    <= 1'b0;
         shift_ff      <= '0;
         rem_ff        <= '0;
         pend_valid_ff <= 1'b0;
         pend_sym_ff   <= '0;
         pend_err_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         root_ff       <= root_in;
         root_left_ff  <= root_left_in;
         root_right_ff <= root_right_in;
         cur_node_ff   <= cur_node_in;
         cur_left_ff   <= cur_left_in;
         cur_right_ff  <= cur_right_in;
         refetch_ff    <= refetch_in;
         shift_ff      <= shift_in;
         rem_ff        <= rem_in;
         pend_valid_ff <= pend_valid_in;
         pend_sym_ff   <= pend_sym_in;
         pend_err_ff   <= pend_err_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_ff        <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[item.node] <= {item.left, item.right};
      end
      if (rd_en) begin
         node_rd_ff  <= node_mem[rd_addr];
         rd_node_ff  <= rd_addr;
         rd_symok_ff <= rd_symok;
      end
   end

   always_ff @(posedge clock) begin
      if (sym_we) begin
         sym_mem[sym_wr_addr] <= item.leaf_symbol;
      end
      if (rd_en) begin
         sym_rd_ff <= sym_mem[sym_rd_addr];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `HTWD_ASSERT_IMPLIES(a_pend_in_walk, pend_valid_ff, (state_ff == S_WALK || state_ff == S_FLUSH))
   `HTWD_ASSERT_IMPLIES(a_rsp_source, $rose(rsp_valid_ff), ($past(state_ff) == S_WALK || $past(state_ff) == S_FLUSH))
   `HTWD_ASSERT_NEXT(a_root_done, (state_ff == S_ROOT), (state_ff == S_IDLE))

endmodule

// ===== rtl/huffman_tree_walk_decoder_unit.sv =====
// Huffman tree-walk decoder. Items enter a four-entry queue; the walker applies
// node writes as it pops them, and a decode of k code bits does one node-table
// read per bit, since each bit's address comes from the previous read: it
// issues the first read, follows the bits in S_WALK and releases the final
// symbol with its last flag in S_FLUSH. Zero-bit decodes are dropped at the
// queue. A new symbol count on csr_data makes the walker reload the root via
// S_ROOT before the next item. A decoded symbol waits in a pending register
// until the walk knows whether it is the last one of its code byte, then moves
// to the output register. While rsp_stall holds a result the walker runs on
// and waits only with both registers full, at a further symbol or in S_FLUSH.
module huffman_tree_walk_decoder_unit
   import htwd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [NODE_W-1:0] csr_data
);

   queue_out_type q_link;
   logic          q_pop;

   htwd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_out       (q_link),
      .q_pop       (q_pop)
   );

   htwd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_in        (q_link),
      .q_pop       (q_pop),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
